>>> rtl/aging_linear_probe_hash_table_core_macros.svh
// Assertion macros used by the hash table top level.
`ifndef AGING_LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define AGING_LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

// Checks that a condition implies a property in the same cycle.
`define ALPH_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash table assertion failed");

// Checks that a condition implies a property in the next cycle.
`define ALPH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash table assertion failed");

`endif

>>> rtl/alph_pkg.sv
// Types and constants of the aging linear-probe hash table.
package alph_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int BUCKET_MULT = 23;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_SWEEP  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	localparam logic [1:0] KIND_10 = 2'd0;
	localparam logic [1:0] KIND_12 = 2'd1;

	localparam logic [1:0] STATUS_INSERTED  = 2'd0;
	localparam logic [1:0] STATUS_REFRESHED = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EVAL
	} bk_state_t;

	typedef struct packed {
		logic [63:0] head;
		logic [23:0] tail;
		logic [21:0] key;
		logic [7:0]  age;
	} entry_t;

	typedef struct packed {
		op_t            op;
		logic           skip;
		logic [1:0]     kind;
		logic [21:0]    key;
		logic [63:0]    head;
		logic [23:0]    tail;
		logic [7:0]     limit;
		logic [IDX_W-1:0] start;
	} task_t;

endpackage

>>> rtl/aging_linear_probe_hash_table_core.sv
// Top level of the aging linear-probe callsign hash table.
// Usage: drive a command on operation and the payload ports and raise start; the command is
// taken at a rising edge where start is high and busy is low. busy is high while the
// two-entry command queue is full. Each command produces exactly one result, shown for one
// cycle with done high; the receiver cannot hold results off and must take them then.
// Add and lookup read the entry memory once per probe, each probe a read state (address)
// and then an evaluate state (registered read data); done rises after the last probe of
// a command, probes from 1 to 256, and the engine is then free for the next one. The age
// sweep visits all 256 entries. An add with an empty callsign or the unused operation
// code finishes without a probe. The entry memory is single-port with a registered read.
// The front end keeps taking commands into the queue while the engine works. Reset empties
// the table at once through per-entry occupancy flip-flops and zeroes the count; no
// clearing pass is needed.
module aging_linear_probe_hash_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [21:0] hash_key,
	input  logic [1:0]  hash_kind,
	input  logic [63:0] name_head,
	input  logic [23:0] name_tail,
	input  logic [7:0]  age_limit,
	output logic        done,
	output logic        found,
	output logic [63:0] result_head,
	output logic [23:0] result_tail,
	output logic [8:0]  entry_count,
	output logic [1:0]  add_status
);
	import alph_pkg::*;

	`include "aging_linear_probe_hash_table_core_macros.svh"

	logic  push;
	logic  pop;
	logic  full;
	logic  empty;
	task_t front_task;
	task_t queue_task;

	assign busy = full;

	alph_front u_front (
		.start     (start),
		.full      (full),
		.operation (operation),
		.hash_key  (hash_key),
		.hash_kind (hash_kind),
		.name_head (name_head),
		.name_tail (name_tail),
		.age_limit (age_limit),
		.push      (push),
		.task_out  (front_task)
	);

	alph_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_task),
		.pop    (pop),
		.dout   (queue_task),
		.full   (full),
		.empty  (empty)
	);

	alph_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.task_in     (queue_task),
		.pop         (pop),
		.done        (done),
		.found       (found),
		.result_head (result_head),
		.result_tail (result_tail),
		.entry_count (entry_count),
		.add_status  (add_status)
	);

	`ALPH_ASSERT_IMPL(a_count_bound, done, entry_count <= 9'(TABLE_DEPTH))
	`ALPH_ASSERT_IMPL(a_found_no_status, done && found, add_status == STATUS_INSERTED)
	`ALPH_ASSERT_NEXT(a_push_fills, full && !pop, busy)
	`ALPH_ASSERT_IMPL(a_no_pop_empty, pop, !empty)

endmodule

>>> rtl/alph_front.sv
// Front end: accepts commands, normalizes callsigns and computes the first probe slot.
module alph_front (
	input  logic                 start,
	input  logic                 full,
	input  logic [1:0]           operation,
	input  logic [21:0]          hash_key,
	input  logic [1:0]           hash_kind,
	input  logic [63:0]          name_head,
	input  logic [23:0]          name_tail,
	input  logic [7:0]           age_limit,
	output logic                 push,
	output alph_pkg::task_t      task_out
);
	import alph_pkg::*;

	logic [87:0] chars;
	logic [87:0] norm;
	logic [9:0]  bucket;
	logic [14:0] prod;
	op_t         op;

	assign op = op_t'(operation);
	assign push = start && !full;
	assign chars = {name_head, name_tail};

	// Every character after the first zero character is forced to zero.
	always_comb begin
		logic ended;
		ended = 1'b0;
		norm = chars;
		for (int i = 0; i < 11; i++) begin
			if (ended) begin
				norm[87 - 8 * i -: 8] = 8'h00;
			end else if (chars[87 - 8 * i -: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
	end

	always_comb begin
		bucket = hash_key[21:12];
		if (op == OP_LOOKUP) begin
			if (hash_kind == KIND_10) begin
				bucket = hash_key[9:0];
			end else if (hash_kind == KIND_12) begin
				bucket = hash_key[11:2];
			end
		end
	end

	assign prod = 15'(bucket * 15'(BUCKET_MULT));

	always_comb begin
		task_out.op    = op;
		task_out.skip  = (op == OP_NOP) || (op == OP_ADD && name_head[63:56] == 8'h00);
		task_out.kind  = hash_kind;
		task_out.key   = hash_key;
		task_out.head  = norm[87:24];
		task_out.tail  = norm[23:0];
		task_out.limit = age_limit;
		task_out.start = (op == OP_SWEEP) ? '0 : IDX_W'(prod % TABLE_DEPTH);
	end

endmodule

>>> rtl/alph_queue.sv
// Two-entry command queue between the front end and the table engine.
module alph_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  alph_pkg::task_t din,
	input  logic            pop,
	output alph_pkg::task_t dout,
	output logic            full,
	output logic            empty
);
	import alph_pkg::*;

	task_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full  = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= 2'(fill_q + {1'b0, push} - {1'b0, pop});
		end
	end

endmodule

>>> rtl/alph_back.sv
// Table engine: entry memory, occupancy bits and the probe and sweep sequencer.
module alph_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      empty,
	input  alph_pkg::task_t           task_in,
	output logic                      pop,
	output logic                      done,
	output logic                      found,
	output logic [63:0]               result_head,
	output logic [23:0]               result_tail,
	output logic [alph_pkg::CNT_W-1:0] entry_count,
	output logic [1:0]                add_status
);
	import alph_pkg::*;

	entry_t           mem [TABLE_DEPTH];
	entry_t           rd_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	bk_state_t        state_q, state_d;
	task_t            item_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] count_q;

	logic             slot_valid;
	logic             last_probe;
	logic [21:0]      key_sel;
	logic             add_match;
	logic             look_match;
	logic             finish;
	logic             wr_en;
	entry_t           wr_data;
	logic             set_valid;
	logic             clr_valid;
	logic [CNT_W-1:0] count_d;
	logic             res_found;
	logic [1:0]       res_status;

	assign slot_valid = valid_q[idx_q];
	assign last_probe = (n_q == CNT_W'(TABLE_DEPTH - 1));

	always_comb begin
		unique case (item_q.kind)
			KIND_10: key_sel = {12'd0, rd_q.key[21:12]};
			KIND_12: key_sel = {10'd0, rd_q.key[21:10]};
			default: key_sel = rd_q.key;
		endcase
	end

	assign add_match = slot_valid && rd_q.key == item_q.key && rd_q.head == item_q.head
		&& rd_q.tail == item_q.tail;
	assign look_match = slot_valid && key_sel == item_q.key;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty && !task_in.skip) begin
					state_d = BK_READ;
				end
			end
			BK_READ: state_d = BK_EVAL;
			BK_EVAL: state_d = finish ? BK_IDLE : BK_READ;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = (state_q == BK_IDLE) && !empty;
		finish     = 1'b0;
		wr_en      = 1'b0;
		wr_data    = rd_q;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		count_d    = count_q;
		res_found  = 1'b0;
		res_status = STATUS_INSERTED;
		if (state_q == BK_EVAL) begin
			unique case (item_q.op)
				OP_ADD: begin
					if (!slot_valid) begin
						finish    = 1'b1;
						wr_en     = 1'b1;
						wr_data   = '{head: item_q.head, tail: item_q.tail,
							key: item_q.key, age: 8'd0};
						set_valid = 1'b1;
						count_d   = CNT_W'(count_q + 1'b1);
					end else if (add_match) begin
						finish     = 1'b1;
						wr_en      = 1'b1;
						wr_data.age = 8'd0;
						res_status = STATUS_REFRESHED;
					end else if (last_probe) begin
						finish     = 1'b1;
						res_status = STATUS_FULL;
					end
				end
				OP_LOOKUP: begin
					if (!slot_valid || look_match || last_probe) begin
						finish    = 1'b1;
						res_found = look_match;
					end
				end
				default: begin
					finish = last_probe;
					if (slot_valid) begin
						if (rd_q.age > item_q.limit) begin
							clr_valid = 1'b1;
							if (count_q != '0) begin
								count_d = CNT_W'(count_q - 1'b1);
							end
						end else begin
							wr_en       = 1'b1;
							wr_data.age = 8'(rd_q.age + 1'b1);
						end
					end
				end
			endcase
		end
	end

	function automatic logic done_set();
		return (pop && task_in.skip) || (state_q == BK_EVAL && finish);
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == BK_READ) begin
			rd_q <= mem[idx_q];
		end
		if (wr_en) begin
			mem[idx_q] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= task_in;
		end
		if (done_set()) begin
			result_head <= '0;
			result_tail <= '0;
			if (state_q == BK_EVAL && res_found) begin
				result_head <= rd_q.head;
				result_tail <= rd_q.tail;
			end
			found       <= (state_q == BK_EVAL) && res_found;
			add_status  <= (state_q == BK_EVAL) ? res_status : STATUS_INSERTED;
			entry_count <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			n_q     <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done    <= done_set();
			if (set_valid) begin
				valid_q[idx_q] <= 1'b1;
			end else if (clr_valid) begin
				valid_q[idx_q] <= 1'b0;
			end
			if (pop) begin
				idx_q <= task_in.start;
				n_q   <= '0;
			end else if (state_q == BK_EVAL && !finish) begin
				idx_q <= (idx_q == IDX_W'(TABLE_DEPTH - 1)) ? '0 : IDX_W'(idx_q + 1'b1);
				n_q   <= CNT_W'(n_q + 1'b1);
			end
		end
	end

endmodule
